/* rtl/core/fss_pkg.sv */
package fss_pkg;

   localparam int ALPHA_FRAC_BITS = 16;
   localparam int MAX_SHOTS       = 256;

   localparam int ALPHA_W   = ALPHA_FRAC_BITS + 1;
   localparam int DUR_W     = 26;
   localparam int COUNT_W   = 9;
   localparam int SHOT_W    = 8;
   localparam int TIMER_W   = 32;
   localparam int DT_W      = 20;
   localparam int CSR_IDX_W = 3;
   localparam int DIV_CNT_W = 5;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC_BITS;
   // alpha * 1000 > ONE is the same as alpha > floor(ONE / 1000)
   localparam logic [ALPHA_W-1:0] FADE_ON_LIMIT = ALPHA_W'((1 << ALPHA_FRAC_BITS) / 1000);
   localparam logic [DUR_W-1:0]   MIN_DUR_US    = DUR_W'(10000);
   localparam logic [COUNT_W-1:0] MAX_COUNT     = COUNT_W'(MAX_SHOTS);

   typedef enum logic [1:0] {
      PH_IN,
      PH_HOLD,
      PH_OUT,
      PH_BLACK
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FADE_TIME,
      CSR_HOLD_TIME,
      CSR_BLACK_TIME,
      CSR_SHOT_COUNT,
      CSR_START_INDEX
   } csr_index_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EVAL,
      SEQ_DIV_LOAD,
      SEQ_DIV_WAIT,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic                 go;
      logic [DUR_W-1:0]     rem_init;
      logic [COUNT_W-1:0]   num_init;
      logic [DUR_W-1:0]     divisor;
      logic [DIV_CNT_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic [ALPHA_FRAC_BITS-1:0] quot;
      logic [DUR_W-1:0]           rem;
   } div_rsp_type;

   function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] count);
      return (count > MAX_COUNT) ? MAX_COUNT : count;
   endfunction

   function automatic logic [SHOT_W-1:0] clamp_start(input logic [COUNT_W-1:0] count,
                                                     input logic [SHOT_W-1:0]  start);
      logic [COUNT_W-1:0] n;
      logic [COUNT_W-1:0] last;
      n    = eff_count(count);
      last = n - COUNT_W'(1);
      if (n == '0) begin
         return '0;
      end
      if (COUNT_W'(start) > last) begin
         return last[SHOT_W-1:0];
      end
      return start;
   endfunction

   function automatic logic [DUR_W-1:0] min_dur(input logic [DUR_W-1:0] dur);
      return (dur < MIN_DUR_US) ? MIN_DUR_US : dur;
   endfunction

endpackage

/* rtl/core/fss_if.sv */
interface fss_req_if import fss_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            kind;
   logic [DT_W-1:0] elapsed_us;
   logic            cycling;
   logic            camera_active;

   modport source (output valid, kind, elapsed_us, cycling, camera_active, input ready);
   modport sink   (input valid, kind, elapsed_us, cycling, camera_active, output ready);
endinterface

interface fss_rsp_if import fss_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ALPHA_W-1:0] alpha;
   logic               fade_enabled;
   logic               alpha_written;
   logic [SHOT_W-1:0]  shot_index;
   logic               shot_applied;
   logic [1:0]         phase_now;

   modport source (output valid, alpha, fade_enabled, alpha_written, shot_index,
                   shot_applied, phase_now, input ready);
   modport sink   (input valid, alpha, fade_enabled, alpha_written, shot_index,
                   shot_applied, phase_now, output ready);
endinterface

interface fss_csr_if import fss_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DUR_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/fade_slideshow_sequencer.sv */
// Slideshow fade sequencer: one request item per display frame (a frame tick or a start event)
// gives exactly one response item with the fade alpha (Q1.16, 65536 fully black), the current
// shot and the phase. Items are handled one at a time; req ready is low while an item is in
// work. A frame that needs no ramp goes from acceptance through evaluation to the done state and
// the response register; a ramp frame in fade-in or fade-out and the frame that advances the shot
// also pass through the shared restoring divider, which resolves one quotient bit per
// cycle (16 bits of alpha, or 9 bits for the shot-count modulo). A finished response waits in
// its own register, so the next item is taken while it is still unread. Configuration writes
// are always accepted and must only be issued while no item is in work.
module fade_slideshow_sequencer import fss_pkg::*; (
   input logic       clock,
   input logic       reset,
   fss_req_if.sink   req_bus,
   fss_rsp_if.source rsp_bus,
   fss_csr_if.sink   csr_bus
);

   seq_state_type state_ff, state_in;

   logic [DUR_W-1:0]   fade_ff, fade_in;
   logic [DUR_W-1:0]   hold_ff, hold_in;
   logic [DUR_W-1:0]   black_ff, black_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SHOT_W-1:0]  start_ff, start_in;

   phase_type          phase_ff, phase_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [SHOT_W-1:0]  shot_ff, shot_in;
   logic               was_cyc_ff, was_cyc_in;
   logic               susp_ff, susp_in;
   logic               started_ff, started_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;

   logic               kind_ff, kind_in;
   logic [DT_W-1:0]    dt_ff, dt_in;
   logic               cyc_ff, cyc_in;
   logic               cam_ff, cam_in;

   logic               written_ff, written_in;
   logic               applied_ff, applied_in;
   logic               mod_ff, mod_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ALPHA_W-1:0] rsp_alpha_ff, rsp_alpha_in;
   logic               rsp_fade_ff, rsp_fade_in;
   logic               rsp_written_ff, rsp_written_in;
   logic [SHOT_W-1:0]  rsp_shot_ff, rsp_shot_in;
   logic               rsp_applied_ff, rsp_applied_in;
   logic [1:0]         rsp_phase_ff, rsp_phase_in;

   logic [DUR_W-1:0]   fade_dur;
   logic [COUNT_W-1:0] n_shots;

   div_req_type div_req;
   div_rsp_type div_rsp;

   assign fade_dur = min_dur(fade_ff);
   assign n_shots  = eff_count(count_ff);

   fss_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ramp: remainder starts at the timer, zeros shift in; shot advance: (shot + 1) mod count
   always_comb begin
      div_req.go       = (state_ff == SEQ_DIV_LOAD);
      div_req.rem_init = mod_ff ? '0 : timer_ff[DUR_W-1:0];
      div_req.num_init = mod_ff ? (COUNT_W'(shot_ff) + COUNT_W'(1)) : '0;
      div_req.divisor  = mod_ff ? DUR_W'(n_shots) : fade_dur;
      div_req.steps    = mod_ff ? DIV_CNT_W'(COUNT_W) : DIV_CNT_W'(ALPHA_FRAC_BITS);
   end

   always_comb begin
      logic               run;
      logic               need_div;
      phase_type          phase_v;
      logic [TIMER_W-1:0] timer_v;
      logic [TIMER_W:0]   sum_wide;
      logic [TIMER_W-1:0] sum;

      state_in       = state_ff;
      fade_in        = fade_ff;
      hold_in        = hold_ff;
      black_in       = black_ff;
      count_in       = count_ff;
      start_in       = start_ff;
      phase_in       = phase_ff;
      timer_in       = timer_ff;
      shot_in        = shot_ff;
      was_cyc_in     = was_cyc_ff;
      susp_in        = susp_ff;
      started_in     = started_ff;
      alpha_in       = alpha_ff;
      kind_in        = kind_ff;
      dt_in          = dt_ff;
      cyc_in         = cyc_ff;
      cam_in         = cam_ff;
      written_in     = written_ff;
      applied_in     = applied_ff;
      mod_in         = mod_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_alpha_in   = rsp_alpha_ff;
      rsp_fade_in    = rsp_fade_ff;
      rsp_written_in = rsp_written_ff;
      rsp_shot_in    = rsp_shot_ff;
      rsp_applied_in = rsp_applied_ff;
      rsp_phase_in   = rsp_phase_ff;

      run      = 1'b0;
      need_div = 1'b0;
      phase_v  = phase_ff;
      timer_v  = timer_ff;
      sum_wide = '0;
      sum      = '0;

      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_FADE_TIME:   fade_in  = csr_bus.data;
            CSR_HOLD_TIME:   hold_in  = csr_bus.data;
            CSR_BLACK_TIME:  black_in = csr_bus.data;
            CSR_SHOT_COUNT:  count_in = csr_bus.data[COUNT_W-1:0];
            CSR_START_INDEX: start_in = csr_bus.data[SHOT_W-1:0];
            default: ;
         endcase
         if ((csr_bus.index == CSR_SHOT_COUNT || csr_bus.index == CSR_START_INDEX)
             && !started_ff) begin
            shot_in = clamp_start(count_in, start_in);
         end
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (req_bus.valid) begin
               kind_in  = req_bus.kind;
               dt_in    = req_bus.elapsed_us;
               cyc_in   = req_bus.cycling;
               cam_in   = req_bus.camera_active;
               state_in = SEQ_EVAL;
            end
         end

         SEQ_EVAL: begin
            written_in = 1'b0;
            applied_in = 1'b0;
            mod_in     = 1'b0;
            if (kind_ff) begin
               shot_in    = clamp_start(count_ff, start_ff);
               phase_in   = PH_IN;
               timer_in   = '0;
               was_cyc_in = cyc_ff;
               susp_in    = !cam_ff;
               started_in = 1'b1;
               applied_in = (n_shots != '0);
               alpha_in   = (!cam_ff || !cyc_ff) ? '0 : ALPHA_ONE;
               written_in = 1'b1;
            end else if (started_ff && n_shots != '0) begin
               run = 1'b1;
               if (!cyc_ff) begin
                  if (was_cyc_ff) begin
                     alpha_in   = '0;
                     written_in = 1'b1;
                     was_cyc_in = 1'b0;
                  end
                  run = 1'b0;
               end else if (!was_cyc_ff) begin
                  // rotation back on: restart the sequence from fade-in
                  phase_v    = PH_IN;
                  timer_v    = '0;
                  phase_in   = PH_IN;
                  timer_in   = '0;
                  was_cyc_in = 1'b1;
               end
               if (run && !cam_ff) begin
                  // suspended: phase and timer kept for when the camera returns
                  if (!susp_ff) begin
                     alpha_in   = '0;
                     written_in = 1'b1;
                     susp_in    = 1'b1;
                  end
                  run = 1'b0;
               end
               if (run) begin
                  susp_in    = 1'b0;
                  written_in = 1'b1;
                  sum_wide   = {1'b0, timer_v} + (TIMER_W + 1)'(dt_ff);
                  sum        = sum_wide[TIMER_W] ? '1 : sum_wide[TIMER_W-1:0];
                  timer_in   = sum;
                  case (phase_v)
                     PH_IN: begin
                        if (sum >= TIMER_W'(fade_dur)) begin
                           alpha_in = '0;
                           phase_in = PH_HOLD;
                           timer_in = '0;
                        end else begin
                           need_div = 1'b1;
                        end
                     end
                     PH_HOLD: begin
                        alpha_in = '0;
                        if (sum >= TIMER_W'(min_dur(hold_ff))) begin
                           phase_in = PH_OUT;
                           timer_in = '0;
                        end
                     end
                     PH_OUT: begin
                        if (sum >= TIMER_W'(fade_dur)) begin
                           alpha_in   = ALPHA_ONE;
                           applied_in = 1'b1;
                           phase_in   = PH_BLACK;
                           timer_in   = '0;
                           mod_in     = 1'b1;
                           need_div   = 1'b1;
                        end else begin
                           need_div = 1'b1;
                        end
                     end
                     default: begin
                        alpha_in = ALPHA_ONE;
                        if (sum >= TIMER_W'(black_ff)) begin
                           phase_in = PH_IN;
                           timer_in = '0;
                        end
                     end
                  endcase
               end
            end
            state_in = need_div ? SEQ_DIV_LOAD : SEQ_DONE;
         end

         SEQ_DIV_LOAD: begin
            state_in = SEQ_DIV_WAIT;
         end

         SEQ_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (mod_ff) begin
                  shot_in = div_rsp.rem[SHOT_W-1:0];
               end else if (phase_ff == PH_IN) begin
                  alpha_in = ALPHA_ONE - ALPHA_W'(div_rsp.quot);
               end else begin
                  alpha_in = ALPHA_W'(div_rsp.quot);
               end
               state_in = SEQ_DONE;
            end
         end

         SEQ_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_alpha_in   = alpha_ff;
               rsp_fade_in    = (alpha_ff > FADE_ON_LIMIT);
               rsp_written_in = written_ff;
               rsp_shot_in    = shot_ff;
               rsp_applied_in = applied_ff;
               rsp_phase_in   = phase_ff;
               state_in       = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         fade_ff      <= DUR_W'(500000);
         hold_ff      <= DUR_W'(3000000);
         black_ff     <= DUR_W'(200000);
         count_ff     <= COUNT_W'(1);
         start_ff     <= '0;
         phase_ff     <= PH_IN;
         timer_ff     <= '0;
         shot_ff      <= '0;
         was_cyc_ff   <= 1'b0;
         susp_ff      <= 1'b0;
         started_ff   <= 1'b0;
         alpha_ff     <= '0;
         written_ff   <= 1'b0;
         applied_ff   <= 1'b0;
         mod_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fade_ff      <= fade_in;
         hold_ff      <= hold_in;
         black_ff     <= black_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         shot_ff      <= shot_in;
         was_cyc_ff   <= was_cyc_in;
         susp_ff      <= susp_in;
         started_ff   <= started_in;
         alpha_ff     <= alpha_in;
         written_ff   <= written_in;
         applied_ff   <= applied_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      dt_ff          <= dt_in;
      cyc_ff         <= cyc_in;
      cam_ff         <= cam_in;
      rsp_alpha_ff   <= rsp_alpha_in;
      rsp_fade_ff    <= rsp_fade_in;
      rsp_written_ff <= rsp_written_in;
      rsp_shot_ff    <= rsp_shot_in;
      rsp_applied_ff <= rsp_applied_in;
      rsp_phase_ff   <= rsp_phase_in;
   end

   assign req_bus.ready         = (state_ff == SEQ_IDLE);
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.alpha         = rsp_alpha_ff;
   assign rsp_bus.fade_enabled  = rsp_fade_ff;
   assign rsp_bus.alpha_written = rsp_written_ff;
   assign rsp_bus.shot_index    = rsp_shot_ff;
   assign rsp_bus.shot_applied  = rsp_applied_ff;
   assign rsp_bus.phase_now     = rsp_phase_ff;

`ifndef SYNTHESIS
   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      alpha_ff <= ALPHA_ONE)
      else $error("alpha beyond full black");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == SEQ_DIV_WAIT)
      else $error("divider finished outside the wait state");

   a_ramp_below_fade: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_DIV_LOAD && !mod_ff) |-> timer_ff < TIMER_W'(fade_dur))
      else $error("ramp division started with timer at or past fade time");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> state_ff == SEQ_EVAL)
      else $error("accepted item not evaluated");
`endif

endmodule

/* rtl/core/fss_div.sv */
// Restoring divider, one quotient bit per cycle.
// Numerator bits are shifted in from num, MSB first, below the running remainder.
module fss_div import fss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DUR_W-1:0]           rem_ff, rem_in;
   logic [COUNT_W-1:0]         num_ff, num_in;
   logic [DUR_W-1:0]           divisor_ff, divisor_in;
   logic [ALPHA_FRAC_BITS-1:0] quot_ff, quot_in;

   logic [DUR_W:0] trial;
   logic [DUR_W:0] diff;
   logic           fits;

   assign trial = {rem_ff, num_ff[COUNT_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      num_in     = num_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      if (req.go) begin
         busy_in    = 1'b1;
         cnt_in     = req.steps;
         rem_in     = req.rem_init;
         num_in     = req.num_init;
         divisor_in = req.divisor;
         quot_in    = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top bit drops out either way
         rem_in  = fits ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
         num_in  = {num_ff[COUNT_W-2:0], 1'b0};
         quot_in = {quot_ff[ALPHA_FRAC_BITS-2:0], fits};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule
